[hdl/tsa_pkg.sv]
// ----------------------------------------------------------------------------
// tsa_pkg
// Types and constants shared by the triangle strip assembler and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

  localparam int unsigned IndexWidth = 16;
  localparam int unsigned FillWidth  = 2;

  typedef logic [IndexWidth-1:0] index_t;
  typedef logic [FillWidth-1:0]  fill_t;

  // index value that restarts the strip
  localparam index_t RestartIndex = 16'hFFFF;
  // indices needed before the first triangle of a strip closes
  localparam fill_t  FillAtStart  = 2'd3;
  localparam fill_t  FillClosing  = 2'd1;

  typedef struct packed {
    index_t first;
    index_t second;
    index_t third;
  } triangle_t;

endpackage

`default_nettype wire

[hdl/triangle_strip_assembler_top.sv]
// ----------------------------------------------------------------------------
// triangle_strip_assembler_top
// Turns a triangle strip index stream with primitive restart into a list of
// non-degenerate triangles with alternating winding.
// ----------------------------------------------------------------------------
// a closing triangle is registered into the output register, or into skid on a stall
// throughput: one index per cycle unless skid is full; history updates in one pass
// a two-entry output buffer (output register plus skid) takes one more triangle
// while the output stalls; input stops only once both entries are full
// reset: history cleared to zero, fill count to three, parity even, no output
`default_nettype none

module triangle_strip_assembler_top (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  tsa_pkg::index_t strip_index_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output tsa_pkg::index_t corner_first_o,
  output tsa_pkg::index_t corner_second_o,
  output tsa_pkg::index_t corner_third_o
);
  import tsa_pkg::*;

  index_t    newest_q, newest_d;
  index_t    older_q, older_d;
  fill_t     fill_q, fill_d;
  logic      parity_q, parity_d;

  triangle_t out_q, skid_q, tri_new;
  logic      out_valid_q, skid_valid_q;

  logic      in_fire, out_fire, restart, closes, degenerate, emit;

  assign in_ready_o = ~skid_valid_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = out_valid_q & out_ready_i;

  assign restart    = (strip_index_i == RestartIndex);
  // zero is unreachable but behaves like one
  assign closes     = (fill_q <= FillClosing);
  assign degenerate = (strip_index_i == newest_q) | (newest_q == older_q)
                    | (strip_index_i == older_q);
  assign emit       = in_fire & ~restart & closes & ~degenerate;

  always_comb begin
    tri_new.second = newest_q;
    if (parity_q) begin
      tri_new.first = older_q;
      tri_new.third = strip_index_i;
    end else begin
      tri_new.first = strip_index_i;
      tri_new.third = older_q;
    end
  end

  always_comb begin
    newest_d = newest_q;
    older_d  = older_q;
    fill_d   = fill_q;
    parity_d = parity_q;
    if (in_fire) begin
      if (restart) begin
        fill_d   = FillAtStart;
        parity_d = 1'b0;
      end else begin
        newest_d = strip_index_i;
        older_d  = newest_q;
        if (closes) begin
          fill_d   = FillClosing;
          parity_d = ~parity_q;
        end else begin
          fill_d   = fill_q - FillClosing;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      older_q  <= '0;
      fill_q   <= FillAtStart;
      parity_q <= 1'b0;
    end else begin
      newest_q <= newest_d;
      older_q  <= older_d;
      fill_q   <= fill_d;
      parity_q <= parity_d;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (emit) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (emit) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= tri_new;
      end else begin
        out_q <= tri_new;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign corner_first_o  = out_q.first;
  assign corner_second_o = out_q.second;
  assign corner_third_o  = out_q.third;

endmodule

`default_nettype wire

[hdl/tsa_checker.sv]
// ----------------------------------------------------------------------------
// tsa_checker
// Port-level checks for the triangle strip assembler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_checker (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             in_valid_i,
  input wire             in_ready_o,
  input tsa_pkg::index_t strip_index_i,
  input wire             out_valid_o,
  input wire             out_ready_i,
  input tsa_pkg::index_t corner_first_o,
  input tsa_pkg::index_t corner_second_o,
  input tsa_pkg::index_t corner_third_o
);
  import tsa_pkg::*;

  // a waiting index word stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(strip_index_i))
    else $error("input word dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(corner_first_o)
      && $stable(corner_second_o) && $stable(corner_third_o))
    else $error("output word changed while stalled");

  // degenerate triangles never leave the block
  a_no_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> corner_first_o != corner_second_o
      && corner_second_o != corner_third_o && corner_first_o != corner_third_o)
    else $error("degenerate triangle emitted");

  // restart value never enters the history
  a_no_restart_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> corner_first_o != RestartIndex
      && corner_second_o != RestartIndex && corner_third_o != RestartIndex)
    else $error("restart index emitted as a corner");

endmodule

bind triangle_strip_assembler_top tsa_checker u_tsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .strip_index_i   (strip_index_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .corner_first_o  (corner_first_o),
  .corner_second_o (corner_second_o),
  .corner_third_o  (corner_third_o)
);

`default_nettype wire

[verif/tb_triangle_strip_assembler_top.sv]
// ----------------------------------------------------------------------------
// tb_triangle_strip_assembler_top
// Self-checking bench for the triangle strip assembler. A directed burst
// covers restarts, short strips, every kind of degenerate triangle and the
// index extremes. Random strips follow, with idle cycles on both sides, a
// long output stall and a full drain. A scoreboard class predicts each
// triangle and checks the output words in order.
// ----------------------------------------------------------------------------
module tb_triangle_strip_assembler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsa_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomItems = 400;

  class triangle_scoreboard;
    index_t newest;
    index_t older;
    fill_t fill;
    logic odd;
    triangle_t due[$];
    int errors;
    int matched;
    int restarts;
    int dropped;
    int indices;

    function new();
      newest = '0;
      older = '0;
      fill = FillAtStart;
      odd = 1'b0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // advance the strip state by one accepted index word
    function void note_index(index_t idx);
      index_t mid;
      index_t old;
      bit closes;
      indices++;
      if (idx == RestartIndex) begin
        fill = FillAtStart;
        odd = 1'b0;
        restarts++;
        return;
      end
      closes = (fill <= FillClosing);
      if (!closes) fill = fill - 1'b1;
      mid = newest;
      old = older;
      older = newest;
      newest = idx;
      if (!closes) return;
      fill = FillClosing;
      // degenerate triangles still flip the winding
      if (idx == mid || mid == old || idx == old) dropped++;
      else if (odd) due.insert(due.size(), triangle_t'{old, mid, idx});
      else due.insert(due.size(), triangle_t'{idx, mid, old});
      odd = ~odd;
    endfunction

    function void check_triangle(triangle_t got);
      triangle_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected triangle %h %h %h", $time,
                 got.first, got.second, got.third);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.first !== want.first) begin
        $display("%0t: corner_first expected %h actual %h", $time, want.first, got.first);
        errors++;
      end
      if (got.second !== want.second) begin
        $display("%0t: corner_second expected %h actual %h", $time, want.second, got.second);
        errors++;
      end
      if (got.third !== want.third) begin
        $display("%0t: corner_third expected %h actual %h", $time, want.third, got.third);
        errors++;
      end
      if (got === want) matched++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  index_t strip_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  index_t corner_first_o;
  index_t corner_second_o;
  index_t corner_third_o;

  triangle_scoreboard sb = new();
  bit no_idle = 1'b0;
  int hold_cycles = 0;
  int cycle_count = 0;

  triangle_strip_assembler_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .strip_index_i   (strip_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .corner_first_o  (corner_first_o),
    .corner_second_o (corner_second_o),
    .corner_third_o  (corner_third_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d triangles still due", cycle_count, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_index(strip_index_i);
      if (out_valid_o && out_ready_i)
        sb.check_triangle('{corner_first_o, corner_second_o, corner_third_o});
    end
  end

  // result side: random stall per word, long hold-off on request
  initial begin
    int stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (out_valid_o || hold_cycles > 0) break;
      end
      @(negedge clk_i);
    end
  end

  // called and returns at a falling edge
  task automatic send_index(input index_t idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    strip_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_triangles();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // mostly well-formed strips ended by a restart, some noise words
  task automatic send_random_strips(input int n_items);
    int sent;
    int len;
    bit narrow;
    index_t idx;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_index(index_t'($urandom_range(0, 16'hFFFF)));
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        narrow = ($urandom_range(0, 3) == 0);
        repeat (len) begin
          // a narrow pool makes repeated corners likely
          idx = narrow ? index_t'($urandom_range(0, 3)) : index_t'($urandom_range(0, 16'hFFFE));
          send_index(idx);
          sent++;
        end
        if ($urandom_range(0, 4) != 0) begin
          send_index(RestartIndex);
          sent++;
        end
      end
    end
  endtask

  initial begin
    index_t directed[$];
    directed = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hFFFE, 16'h8000,
                 RestartIndex, 16'h0005, 16'h0005, 16'h0006, 16'h0007, 16'h0007,
                 16'h0006, 16'h0008, RestartIndex, RestartIndex, 16'h0001, 16'h0002,
                 16'h0001, 16'hAAAA, 16'h5555, RestartIndex, 16'h0009, RestartIndex,
                 16'h1234};

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_index(directed[i]);
    drain_triangles();

    send_random_strips(RandomItems * 3 / 8);
    drain_triangles();

    no_idle = 1'b1;
    send_random_strips(RandomItems / 4);

    // stall the output while words keep coming so the input backs up
    hold_cycles = 60;
    send_random_strips(RandomItems / 8);
    no_idle = 1'b0;
    drain_triangles();

    send_random_strips(RandomItems / 4);
    drain_triangles();

    $display("covered %0d index words with %0d restarts", sb.indices, sb.restarts);
    $display("checked %0d triangles, %0d degenerate ones predicted dropped",
             sb.matched, sb.dropped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
